/* design/dgdfs_pkg.sv */
// Package for the directed-graph depth-first walk engine.
// Sizes, command kinds, event codes and the walk stack entry type.
// No dependencies.
package dgdfs_pkg;

    // Graph limits
    localparam int MAX_VERTICES = 32;
    localparam int MAX_DEGREE   = 32;

    // Field and storage widths
    localparam int VTX_W  = 5;                               // vertex number
    localparam int CNT_W  = 6;                               // vertex_count register
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);          // out-degree, 0..MAX_DEGREE
    localparam int POS_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int ADDR_W = VTX_W + POS_W;                   // neighbour store address
    localparam int SP_W   = $clog2(MAX_VERTICES + 1);        // stack pointer
    localparam int DEPTH  = MAX_VERTICES * (1 << POS_W);     // neighbour store entries

    // APB register map
    localparam int  PADDR_W          = 3;
    localparam int  PDATA_W          = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;                // word index of vertex_count

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(32);

    // Command kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_WALK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Event codes
    localparam logic [2:0] EV_ENTERED    = 3'd0;
    localparam logic [2:0] EV_TREE       = 3'd1;
    localparam logic [2:0] EV_ADDED      = 3'd2;
    localparam logic [2:0] EV_BAD_VERTEX = 3'd3;
    localparam logic [2:0] EV_SELF_LOOP  = 3'd4;
    localparam logic [2:0] EV_FULL       = 3'd5;
    localparam logic [2:0] EV_CLEARED    = 3'd6;

    // One level of the walk: vertex and next neighbour position
    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic [DEG_W-1:0] pos;
    } stack_entry_t;

endpackage

/* design/directed_graph_dfs_order.sv */
// Directed-graph depth-first walk engine: edge lists, walk sequencer, event output.
// Add edge and clear each pass through their command state (S_ADD, S_CLR) before their
// word is registered; a walk holds the engine while the sequencer picks roots (S_ROOT),
// pops or scans stack levels (S_TOP, S_NB) and descends (S_ENT), one neighbour at a time.
// One command is in flight at a time; an output stall holds the sequencer while it has a word to present.
// Reset (rst_n low, asynchronous): vertex_count 32, all out-degrees and marks zero.
// Depends on dgdfs_pkg.
module directed_graph_dfs_order
    import dgdfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [1:0]         kind,
    input  logic [VTX_W-1:0]   src_vertex,
    input  logic [VTX_W-1:0]   dst_vertex,
    // event channel
    output logic               evt_valid,
    input  logic               evt_stall,
    output logic [2:0]         event_res,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_TOP  = 3'd4;
    localparam logic [2:0] S_NB   = 3'd5;
    localparam logic [2:0] S_ENT  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        vertex_count_reg;
    logic [VTX_W-1:0]        src_reg, src_next;
    logic [VTX_W-1:0]        dst_reg, dst_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [CNT_W-1:0]        root_reg, root_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    logic                    evt_valid_reg, evt_valid_next;
    logic [2:0]              evt_code_reg, evt_code_next;

    logic [DEG_W-1:0]        deg_reg [MAX_VERTICES];
    stack_entry_t            stk_reg [MAX_VERTICES];
    logic [VTX_W-1:0]        mem [DEPTH];
    logic [VTX_W-1:0]        mem_rdata_reg;

    logic                    cfg_wr;
    logic [CNT_W-1:0]        n_eff;
    logic                    emit_ok;
    logic [VTX_W-1:0]        top_idx;
    stack_entry_t            top;
    logic [VTX_W-1:0]        deg_idx;
    logic [DEG_W-1:0]        deg_cur;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rd_en;
    logic                    nb_ok;
    logic                    deg_inc, deg_clr, mem_we;
    logic                    stk_we;
    logic [VTX_W-1:0]        stk_wr_idx;
    stack_entry_t            stk_wr_data;

    // APB: single register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(vertex_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            vertex_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Shared decode: effective count, stack top, degree lookup, neighbour check
    assign n_eff   = (vertex_count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                               : vertex_count_reg;
    assign emit_ok = !evt_valid_reg || !evt_stall;
    assign top_idx = VTX_W'(sp_reg - SP_W'(1));
    assign top     = stk_reg[top_idx];
    assign deg_idx = (state_reg == S_ADD) ? src_reg : top.vtx;
    assign deg_cur = deg_reg[deg_idx];
    assign rd_addr = {top.vtx, top.pos[POS_W-1:0]};
    assign nb_ok   = ({1'b0, mem_rdata_reg} < n_eff) && !visited_reg[mem_rdata_reg];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        visited_next   = visited_reg;
        root_next      = root_reg;
        sp_next        = sp_reg;
        evt_code_next  = evt_code_reg;
        evt_valid_next = evt_valid_reg && evt_stall;
        deg_inc        = 1'b0;
        deg_clr        = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        stk_we         = 1'b0;
        stk_wr_idx     = top_idx;
        stk_wr_data    = top;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    src_next = src_vertex;
                    dst_next = dst_vertex;
                    case (kind)
                        KIND_ADD:   state_next = S_ADD;
                        KIND_CLEAR: state_next = S_CLR;
                        KIND_WALK:
                        begin
                            visited_next = '0;
                            root_next    = '0;
                            state_next   = S_ROOT;
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            // edge checks in priority order, then append
            S_ADD:
            begin
                if (emit_ok)
                begin
                    evt_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (({1'b0, src_reg} >= n_eff) || ({1'b0, dst_reg} >= n_eff))
                        evt_code_next = EV_BAD_VERTEX;
                    else if (src_reg == dst_reg)
                        evt_code_next = EV_SELF_LOOP;
                    else if (deg_cur >= DEG_W'(MAX_DEGREE))
                        evt_code_next = EV_FULL;
                    else
                    begin
                        evt_code_next = EV_ADDED;
                        mem_we        = 1'b1;
                        deg_inc       = 1'b1;
                    end
                end
            end

            S_CLR:
            begin
                if (emit_ok)
                begin
                    evt_valid_next = 1'b1;
                    evt_code_next  = EV_CLEARED;
                    deg_clr        = 1'b1;
                    visited_next   = '0;
                    state_next     = S_IDLE;
                end
            end

            // pick the next unvisited root
            S_ROOT:
            begin
                if (root_reg >= n_eff)
                    state_next = S_IDLE;
                else if (visited_reg[root_reg[VTX_W-1:0]])
                    root_next = root_reg + CNT_W'(1);
                else if (emit_ok)
                begin
                    evt_valid_next = 1'b1;
                    evt_code_next  = EV_ENTERED;
                    visited_next[root_reg[VTX_W-1:0]] = 1'b1;
                    stk_we          = 1'b1;
                    stk_wr_idx      = '0;
                    stk_wr_data.vtx = root_reg[VTX_W-1:0];
                    stk_wr_data.pos = '0;
                    sp_next         = SP_W'(1);
                    state_next      = S_TOP;
                end
            end

            // pop a finished level or fetch its next neighbour
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    root_next  = root_reg + CNT_W'(1);
                    state_next = S_ROOT;
                end
                else if (top.pos >= deg_cur)
                    sp_next = sp_reg - SP_W'(1);
                else
                begin
                    rd_en           = 1'b1;
                    stk_we          = 1'b1;
                    stk_wr_data.pos = top.pos + DEG_W'(1);
                    state_next      = S_NB;
                end
            end

            // neighbour word is in mem_rdata_reg
            S_NB:
            begin
                if (!nb_ok)
                    state_next = S_TOP;
                else if (emit_ok)
                begin
                    evt_valid_next = 1'b1;
                    evt_code_next  = EV_TREE;
                    state_next     = S_ENT;
                end
            end

            // descend: mark and push the neighbour
            S_ENT:
            begin
                if (emit_ok)
                begin
                    evt_valid_next = 1'b1;
                    evt_code_next  = EV_ENTERED;
                    visited_next[mem_rdata_reg] = 1'b1;
                    stk_we          = 1'b1;
                    stk_wr_idx      = sp_reg[VTX_W-1:0];
                    stk_wr_data.vtx = mem_rdata_reg;
                    stk_wr_data.pos = '0;
                    sp_next         = sp_reg + SP_W'(1);
                    state_next      = S_TOP;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            visited_reg   <= '0;
            root_reg      <= '0;
            sp_reg        <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            visited_reg   <= visited_next;
            root_reg      <= root_next;
            sp_reg        <= sp_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        evt_code_reg <= evt_code_next;
    end

    // Out-degree per vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                deg_reg[i] <= '0;
        end
        else if (deg_clr)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
                deg_reg[i] <= '0;
        end
        else if (deg_inc)
        begin
            deg_reg[src_reg] <= deg_cur + DEG_W'(1);
        end
    end

    // Walk stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_reg[stk_wr_idx] <= stk_wr_data;
    end

    // Neighbour store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{src_reg, deg_cur[POS_W-1:0]}] <= dst_reg;
        if (rd_en)
            mem_rdata_reg <= mem[rd_addr];
    end

    // Ports
    assign cmd_stall = (state_reg != S_IDLE);
    assign evt_valid = evt_valid_reg;
    assign event_res = evt_code_reg;

    // Checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(MAX_VERTICES))
        else $error("walk stack pointer beyond vertex limit");

    a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOP && sp_reg != '0) |-> visited_reg[top.vtx])
        else $error("stack top holds an unvisited vertex");

    // degree is only looked up for a live source or a live stack top
    a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || (state_reg == S_TOP && sp_reg != '0))
            |-> deg_cur <= DEG_W'(MAX_DEGREE))
        else $error("out-degree beyond list limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && evt_stall) |=> ($stable(evt_code_reg) && evt_valid_reg))
        else $error("pending event word overwritten");

endmodule
